@@ rtl/kpc_pkg.sv @@
`timescale 1ns / 1ps

package kpc_pkg;

	typedef enum logic [2:0] {
		M_IDLE   = 3'd0,
		M_PRESS  = 3'd1,
		M_JUDGE  = 3'd2,
		M_ERROR  = 3'd3,
		M_SHORT  = 3'd4,
		M_DOUBLE = 3'd5,
		M_LONG   = 3'd6
	} mode_t;

	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_SHORT  = 3'd1;
	localparam logic [2:0] EV_DOUBLE = 3'd2;
	localparam logic [2:0] EV_LONG   = 3'd3;
	localparam logic [2:0] EV_ERROR  = 3'd4;

	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_A    = 3'd6;
	localparam logic [2:0] KEY_B    = 3'd7;
	localparam logic [2:0] KEY_C    = 3'd3;

	localparam logic [2:0] CFG_LONG_PRESS  = 3'd0;
	localparam logic [2:0] CFG_DOUBLE_GAP  = 3'd1;
	localparam logic [2:0] CFG_HOLD_MARGIN = 3'd2;
	localparam logic [2:0] CFG_MIN_PRESS   = 3'd3;

	localparam logic [15:0] RST_LONG_PRESS  = 16'd3000;
	localparam logic [15:0] RST_DOUBLE_GAP  = 16'd300;
	localparam logic [15:0] RST_HOLD_MARGIN = 16'd100;
	localparam logic [15:0] RST_MIN_PRESS   = 16'd100;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  key;
		logic [31:0] press_time;
		logic [31:0] release_time;
		logic [31:0] handle_start;
		logic        action_done;
	} kpc_state_t;

	typedef struct packed {
		logic [15:0] long_press;
		logic [15:0] double_gap;
		logic [15:0] hold_margin;
		logic [15:0] min_press;
	} kpc_cfg_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [2:0] event_key;
		logic       is_idle;
		logic       is_active;
	} kpc_result_t;

endpackage

@@ rtl/kpc_step.sv @@
`timescale 1ns / 1ps

module kpc_step
	import kpc_pkg::*;
(
	input  kpc_state_t  cur,
	input  kpc_cfg_t    cfg,
	input  logic [31:0] now_ms,
	input  logic [6:0]  keys_down,
	output kpc_state_t  nxt,
	output kpc_result_t res
);

	logic [7:0]  keys_ext;
	logic [2:0]  key_idx;
	logic        key_dn;
	logic [31:0] d_press;
	logic [31:0] d_rel;
	logic [31:0] d_hold;
	logic [31:0] press_len;
	logic        done;

	assign keys_ext  = {1'b0, keys_down};
	assign key_idx   = cur.key - 3'd1;
	assign key_dn    = (cur.key != KEY_NONE) && keys_ext[key_idx];
	assign d_press   = now_ms - cur.press_time;
	assign d_rel     = now_ms - cur.release_time;
	assign d_hold    = now_ms - cur.handle_start;
	assign press_len = cur.release_time - cur.press_time;

	always_comb begin
		nxt           = cur;
		res.event_res = EV_NONE;
		res.event_key = KEY_NONE;
		done          = 1'b0;
		case (cur.mode)
			M_IDLE: begin
				if (keys_ext[KEY_A - 3'd1]) begin
					nxt.key        = KEY_A;
					nxt.press_time = now_ms;
					nxt.mode       = M_PRESS;
				end else if (keys_ext[KEY_B - 3'd1]) begin
					nxt.key        = KEY_B;
					nxt.press_time = now_ms;
					nxt.mode       = M_PRESS;
				end else if (keys_ext[KEY_C - 3'd1]) begin
					nxt.key        = KEY_C;
					nxt.press_time = now_ms;
					nxt.mode       = M_PRESS;
				end
			end
			M_PRESS: begin
				if (d_press > {16'd0, cfg.long_press}) begin
					nxt.handle_start = now_ms;
					nxt.action_done  = 1'b0;
					nxt.mode         = M_LONG;
				end else if (!key_dn) begin
					nxt.release_time = now_ms;
					nxt.mode         = M_JUDGE;
				end
			end
			M_JUDGE: begin
				if (key_dn && (d_rel < {16'd0, cfg.double_gap})) begin
					nxt.handle_start = now_ms;
					nxt.action_done  = 1'b0;
					nxt.mode         = M_DOUBLE;
				end else if (d_rel > {16'd0, cfg.double_gap}) begin
					nxt.handle_start = now_ms;
					nxt.action_done  = 1'b0;
					nxt.mode = (press_len >= {16'd0, cfg.min_press}) ? M_SHORT : M_ERROR;
				end
			end
			M_ERROR: begin
				res.event_res = EV_ERROR;
				res.event_key = cur.key;
				done          = 1'b1;
			end
			M_SHORT: begin
				res.event_res = EV_SHORT;
				res.event_key = cur.key;
				done          = 1'b1;
			end
			M_DOUBLE, M_LONG: begin
				if (!cur.action_done) begin
					res.event_res   = (cur.mode == M_DOUBLE) ? EV_DOUBLE : EV_LONG;
					res.event_key   = cur.key;
					nxt.action_done = 1'b1;
				end
				// The hold margin only runs out in a mode entered on an earlier tick.
				if ((d_hold > {16'd0, cfg.hold_margin}) && !key_dn) begin
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (done) begin
			nxt.mode         = M_IDLE;
			nxt.key          = KEY_NONE;
			nxt.press_time   = 32'd0;
			nxt.release_time = 32'd0;
			nxt.action_done  = 1'b0;
		end
		res.is_idle   = (nxt.mode == M_IDLE);
		res.is_active = (nxt.mode == M_SHORT) || (nxt.mode == M_DOUBLE) ||
			(nxt.mode == M_LONG);
	end

endmodule

@@ rtl/key_press_classifier.sv @@
`timescale 1ns / 1ps

// Classifies presses of keys 6, 7 and 3 as short, double, long or too short from a
// stream of millisecond ticks. Each accepted tick produces exactly one result beat in the
// next cycle, held in an output register; a new tick is accepted every cycle while
// that register is empty or being drained, so the sustained rate is one tick per
// clock, as the state register takes its new state on every accepted tick. Timing
// registers are written through the configuration channel, which is always ready.

module key_press_classifier
	import kpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic [6:0]  keys_down,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [2:0]  event_key,
	output logic        is_idle,
	output logic        is_active,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	kpc_state_t  state_q;
	kpc_state_t  state_nxt;
	kpc_cfg_t    cfg_q;
	kpc_result_t res_nxt;
	kpc_result_t res_q;
	logic        out_valid_q;
	logic        in_acc;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	kpc_step u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.now_ms    (now_ms),
		.keys_down (keys_down),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= M_IDLE;
			state_q.key          <= KEY_NONE;
			state_q.press_time   <= 32'd0;
			state_q.release_time <= 32'd0;
			state_q.handle_start <= 32'd0;
			state_q.action_done  <= 1'b0;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press  <= RST_LONG_PRESS;
			cfg_q.double_gap  <= RST_DOUBLE_GAP;
			cfg_q.hold_margin <= RST_HOLD_MARGIN;
			cfg_q.min_press   <= RST_MIN_PRESS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LONG_PRESS:  cfg_q.long_press  <= cfg_data;
				CFG_DOUBLE_GAP:  cfg_q.double_gap  <= cfg_data;
				CFG_HOLD_MARGIN: cfg_q.hold_margin <= cfg_data;
				CFG_MIN_PRESS:   cfg_q.min_press   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = res_q.event_res;
	assign event_key = res_q.event_key;
	assign is_idle   = res_q.is_idle;
	assign is_active = res_q.is_active;

endmodule

@@ verif/kpc_result_checker.sv @@
`timescale 1ns / 1ps

module kpc_result_checker
	import kpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] now_ms,
	input  logic [6:0]  keys_down,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  event_res,
	input  logic [2:0]  event_key,
	input  logic        is_idle,
	input  logic        is_active,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          results_pending
);

	kpc_cfg_t    timing;
	mode_t       cur_mode;
	logic [2:0]  cur_key;
	logic [31:0] t_press;
	logic [31:0] t_release;
	logic [31:0] t_handle;
	logic        reported;
	kpc_result_t want;
	kpc_result_t expected_results[$];

	function automatic logic key_held(input logic [6:0] keys, input logic [2:0] k);
		if (k == KEY_NONE)
			return 1'b0;
		return keys[k - 3'd1];
	endfunction

	task automatic release_press();
		cur_mode = M_IDLE;
		cur_key = KEY_NONE;
		t_press = '0;
		t_release = '0;
		reported = 1'b0;
	endtask

	task automatic classify_tick(input logic [31:0] now, input logic [6:0] keys);
		kpc_result_t res;
		logic        finished;
		logic [31:0] elapsed;
		res = '0;
		finished = 1'b0;
		case (cur_mode)
		M_IDLE: begin
			if (key_held(keys, KEY_A))
				cur_key = KEY_A;
			else if (key_held(keys, KEY_B))
				cur_key = KEY_B;
			else if (key_held(keys, KEY_C))
				cur_key = KEY_C;
			if (cur_key != KEY_NONE) begin
				t_press = now;
				cur_mode = M_PRESS;
			end
		end
		M_PRESS: begin
			elapsed = now - t_press;
			if (elapsed > 32'(timing.long_press)) begin
				t_handle = now;
				reported = 1'b0;
				cur_mode = M_LONG;
			end else if (!key_held(keys, cur_key)) begin
				t_release = now;
				cur_mode = M_JUDGE;
			end
		end
		M_JUDGE: begin
			elapsed = now - t_release;
			if (key_held(keys, cur_key) && elapsed < 32'(timing.double_gap)) begin
				t_handle = now;
				reported = 1'b0;
				cur_mode = M_DOUBLE;
			end else if (elapsed > 32'(timing.double_gap)) begin
				t_handle = now;
				reported = 1'b0;
				if (32'(t_release - t_press) >= 32'(timing.min_press))
					cur_mode = M_SHORT;
				else
					cur_mode = M_ERROR;
			end
		end
		M_ERROR, M_SHORT: begin
			res.event_res = (cur_mode == M_SHORT) ? EV_SHORT : EV_ERROR;
			res.event_key = cur_key;
			finished = 1'b1;
		end
		M_DOUBLE, M_LONG: begin
			if (!reported) begin
				res.event_res = (cur_mode == M_DOUBLE) ? EV_DOUBLE : EV_LONG;
				res.event_key = cur_key;
				reported = 1'b1;
			end
		end
		default: ;
		endcase
		// A long or double press ends once the margin has passed with the key up.
		if (cur_mode == M_LONG || cur_mode == M_DOUBLE) begin
			elapsed = now - t_handle;
			if (elapsed > 32'(timing.hold_margin) && !key_held(keys, cur_key))
				finished = 1'b1;
		end
		if (finished)
			release_press();
		res.is_idle = (cur_mode == M_IDLE);
		res.is_active = (cur_mode == M_SHORT) || (cur_mode == M_DOUBLE) ||
			(cur_mode == M_LONG);
		expected_results.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [2:0] exp_val,
		input logic [2:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing = '{RST_LONG_PRESS, RST_DOUBLE_GAP, RST_HOLD_MARGIN, RST_MIN_PRESS};
			t_handle = '0;
			release_press();
			expected_results.delete();
			results_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat arrived with no tick waiting for it");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("event_res", want.event_res, event_res);
					check_field("event_key", want.event_key, event_key);
					check_field("is_idle", 3'(want.is_idle), 3'(is_idle));
					check_field("is_active", 3'(want.is_active), 3'(is_active));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_LONG_PRESS:  timing.long_press = cfg_data;
				CFG_DOUBLE_GAP:  timing.double_gap = cfg_data;
				CFG_HOLD_MARGIN: timing.hold_margin = cfg_data;
				CFG_MIN_PRESS:   timing.min_press = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				classify_tick(now_ms, keys_down);
			results_pending = expected_results.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import kpc_pkg::*;

	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          PHASES          = 8;
	localparam int          TICKS_PER_PHASE = 106;
	localparam logic [31:0] ERR_BASE        = 32'hFFFF_FF00;
	localparam logic [31:0] SHORT_BASE      = 32'h0000_1000;
	localparam logic [31:0] DOUBLE_BASE     = 32'hFFFF_FFF0;
	localparam logic [31:0] LONG_BASE       = 32'h0001_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] now_ms;
	logic [6:0]  keys_down;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  event_res;
	logic [2:0]  event_key;
	logic        is_idle;
	logic        is_active;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	int          mismatch_count;
	int          results_pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic [31:0] t_now;
	logic [31:0] t_mark;
	logic [2:0]  hold_key;
	logic        pressed;
	kpc_cfg_t    cur_timing;
	kpc_cfg_t    next_timing;

	key_press_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.now_ms    (now_ms),
		.keys_down (keys_down),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_res (event_res),
		.event_key (event_key),
		.is_idle   (is_idle),
		.is_active (is_active),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	kpc_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.now_ms          (now_ms),
		.keys_down       (keys_down),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_res       (event_res),
		.event_key       (event_key),
		.is_idle         (is_idle),
		.is_active       (is_active),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** key_press_classifier: FAILED **");
		$finish;
	end

	task automatic send_tick(input logic [31:0] now, input logic [6:0] keys);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= now;
		keys_down <= keys;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
	endtask

	task automatic write_timing(input kpc_cfg_t t);
		for (int i = 0; i < 5; i++) begin
			case (i)
			0: begin
				cfg_index <= CFG_LONG_PRESS;
				cfg_data <= t.long_press;
			end
			1: begin
				cfg_index <= CFG_DOUBLE_GAP;
				cfg_data <= t.double_gap;
			end
			2: begin
				cfg_index <= CFG_HOLD_MARGIN;
				cfg_data <= t.hold_margin;
			end
			3: begin
				cfg_index <= CFG_MIN_PRESS;
				cfg_data <= t.min_press;
			end
			default: begin
				// An index past the last register must leave the timing untouched.
				cfg_index <= 3'($urandom_range(int'(CFG_MIN_PRESS) + 1, 7));
				cfg_data <= 16'($urandom);
			end
			endcase
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		cur_timing = t;
	endtask

	task automatic random_tick();
		logic [15:0] span;
		logic [6:0]  keys;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			t_now = t_now + $urandom_range(0, 3);
		end else if (roll < 85) begin
			case ($urandom_range(0, 3))
			0: span = cur_timing.long_press;
			1: span = cur_timing.double_gap;
			2: span = cur_timing.hold_margin;
			default: span = cur_timing.min_press;
			endcase
			t_now = t_mark + 32'(span) + $urandom_range(0, 2) - 32'd1;
		end else if (roll < 95) begin
			t_now = t_now + $urandom_range(0, 5000);
		end else begin
			t_now = $urandom;
		end
		if ($urandom_range(0, 99) < 30) begin
			pressed = !pressed;
			t_mark = t_now;
			if (pressed && $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
				0, 1, 2: hold_key = KEY_A;
				3, 4, 5: hold_key = KEY_B;
				6, 7, 8: hold_key = KEY_C;
				default: hold_key = 3'($urandom_range(1, 7));
				endcase
			end
		end
		keys = pressed ? 7'(7'd1 << (hold_key - 3'd1)) : 7'h00;
		if ($urandom_range(0, 99) < 10)
			keys = keys | 7'($urandom_range(0, 127));
		send_tick(t_now, keys);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		now_ms = '0;
		keys_down = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		t_now = 32'h0002_0000;
		t_mark = 32'h0002_0000;
		hold_key = KEY_A;
		pressed = 1'b0;
		cur_timing = '{RST_LONG_PRESS, RST_DOUBLE_GAP, RST_HOLD_MARGIN, RST_MIN_PRESS};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All keys down picks key 6; the release comes too early and the gap sits on the limit.
		send_tick(ERR_BASE, 7'h00);
		send_tick(ERR_BASE, 7'h7F);
		send_tick(ERR_BASE + 32'd50, 7'h20);
		send_tick(ERR_BASE + 32'd50, 7'h00);
		send_tick(ERR_BASE + 32'd350, 7'h00);
		send_tick(ERR_BASE + 32'd351, 7'h00);
		send_tick(ERR_BASE + 32'd352, 7'h00);

		send_tick(SHORT_BASE, 7'h41);
		send_tick(SHORT_BASE + 32'd100, 7'h01);
		send_tick(SHORT_BASE + 32'd401, 7'h00);
		send_tick(SHORT_BASE + 32'd402, 7'h00);

		send_tick(DOUBLE_BASE, 7'h04);
		send_tick(DOUBLE_BASE + 32'd120, 7'h00);
		send_tick(DOUBLE_BASE + 32'd419, 7'h04);
		send_tick(DOUBLE_BASE + 32'd420, 7'h04);
		send_tick(DOUBLE_BASE + 32'd520, 7'h00);

		send_tick(LONG_BASE, 7'h20);
		send_tick(LONG_BASE + 32'd3000, 7'h20);
		send_tick(LONG_BASE + 32'd3001, 7'h20);
		send_tick(LONG_BASE + 32'd3002, 7'h20);
		send_tick(LONG_BASE + 32'd3200, 7'h20);
		send_tick(LONG_BASE + 32'd3201, 7'h00);

		send_tick(LONG_BASE + 32'd4000, 7'h1B);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 73;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 73;
			end
			default: begin
				send_idle_pct = 33;
				stall_pct = 33;
			end
			endcase
			case (p)
			0: next_timing = '{RST_LONG_PRESS, RST_DOUBLE_GAP, RST_HOLD_MARGIN,
				RST_MIN_PRESS};
			2: next_timing = '0;
			3: next_timing = '1;
			4: next_timing = kpc_cfg_t'({$urandom, $urandom});
			6: next_timing = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
			default: next_timing = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
				16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
			endcase
			write_timing(next_timing);
			for (int i = 0; i < TICKS_PER_PHASE; i++) begin
				if (p == 5 && i == TICKS_PER_PHASE / 2)
					drain();
				random_tick();
			end
		end

		drain();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("** key_press_classifier: PASSED **");
		else
			$display("** key_press_classifier: FAILED **");
		$finish;
	end

endmodule
